// ===== hdl/rrr_pkg.sv =====
// ----------------------------------------------------------------------------
// rrr_pkg
// Shared widths, item and pixel records, and state codes for the rounded
// rectangle outline rasterizer.
// ----------------------------------------------------------------------------
package rrr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 11;
  localparam int COLOR_BITS  = 16;
  localparam int LW_BITS     = 6;
  localparam int HALF_BITS   = LW_BITS - 1;
  localparam int BAND_BITS   = LW_BITS + 1;
  localparam int EDGE_BITS   = COORD_BITS + 2;
  localparam int CIRC_BITS   = RADIUS_BITS + 1;
  localparam int CRAD_BITS   = RADIUS_BITS + 2;
  localparam int DEC_BITS    = 2 * CIRC_BITS + 4;
  localparam int IQ_DEPTH    = 2;
  localparam int OQ_DEPTH    = 4;
  localparam logic [LW_BITS-1:0] LW_RESET = LW_BITS'(1);

  typedef enum logic {
    KIND_DRAW = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                          kind;
    logic signed [COORD_BITS-1:0]   left_x;
    logic signed [COORD_BITS-1:0]   top_y;
    logic signed [COORD_BITS-1:0]   right_x;
    logic signed [COORD_BITS-1:0]   bottom_y;
    logic        [RADIUS_BITS-1:0]  corner_radius;
    logic        [COLOR_BITS-1:0]   color;
  } item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  step_last;
    logic                  shape_done;
  } pixel_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEDGE,
    PH_VEDGE,
    PH_CSTART,
    PH_REG1,
    PH_REG2
  } phase_e;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_EMIT,
    ST_SETTLE,
    ST_SQUARE,
    ST_LAST
  } seq_e;

  typedef enum logic [1:0] {
    SQ_X,
    SQ_Y,
    SQ_R
  } sq_e;

endpackage

// ===== hdl/rrr_front.sv =====
// ----------------------------------------------------------------------------
// rrr_front
// Input side: takes items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rrr_front import rrr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  logic  kind_bit_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_take_i
);

  localparam int PW = $clog2(IQ_DEPTH);

  item_t           mem_q [IQ_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            do_wr, do_rd;
  item_t           cls;

  always_comb begin
    cls      = item_i;
    cls.kind = kind_bit_i ? KIND_TICK : KIND_DRAW;
  end

  assign full_o       = (cnt_q == (PW+1)'(IQ_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign do_wr        = push_i && !full_o;
  assign do_rd        = item_take_i && item_valid_o;

  always_comb begin
    wr_d  = do_wr ? wr_q + PW'(1) : wr_q;
    rd_d  = do_rd ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(do_wr) - (PW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= cls;
    end
  end

endmodule

// ===== hdl/rrr_out_q.sv =====
// ----------------------------------------------------------------------------
// rrr_out_q
// Result queue between the pixel sequencer and the result ports.
// ----------------------------------------------------------------------------
module rrr_out_q import rrr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   pix_valid_i,
  input  pixel_t pix_i,
  output logic   pix_full_o,
  output logic   empty_o,
  input  logic   pop_i,
  output pixel_t pix_o
);

  localparam int PW = $clog2(OQ_DEPTH);

  pixel_t          mem_q [OQ_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]     cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign pix_full_o = (cnt_q == (PW+1)'(OQ_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pix_o      = mem_q[rd_q];
  assign do_wr      = pix_valid_i && !pix_full_o;
  assign do_rd      = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_wr ? wr_q + PW'(1) : wr_q;
    rd_d  = do_rd ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(do_wr) - (PW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= pix_i;
    end
  end

endmodule

// ===== hdl/rrr_back.sv =====
// ----------------------------------------------------------------------------
// rrr_back
// Pixel sequencer: latches shapes, steps edges and midpoint circles, and
// emits each tick's pixels into the result queue.
// ----------------------------------------------------------------------------
module rrr_back import rrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LW_BITS-1:0] line_width_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               item_take_o,
  output logic               pix_valid_o,
  output pixel_t             pix_o,
  input  logic               pix_full_i
);

  localparam int CB = COORD_BITS;
  localparam int EB = EDGE_BITS;
  localparam int DB = DEC_BITS;
  localparam int MB = 2 * (CIRC_BITS + 1);

  seq_e   seq_q, seq_d;
  phase_e phase_q, phase_d;
  sq_e    sq_q, sq_d;
  logic [1:0] k_q, k_d;
  logic       tick_q, tick_d;

  logic [LW_BITS-1:0]           lw_q, lw_d, pass_q, pass_d;
  logic [HALF_BITS-1:0]         half_q, half_d;
  logic signed [CB-1:0]         l_q, l_d, t_q, t_d, r_q, r_d, b_q, b_d;
  logic [RADIUS_BITS-1:0]       rad_q, rad_d;
  logic [COLOR_BITS-1:0]        color_q, color_d;
  logic signed [EB-1:0]         lpr_q, lpr_d, rmr_q, rmr_d, tmr_q, tmr_d, bpr_q, bpr_d;
  logic signed [EB-1:0]         edge_q, edge_d;
  logic signed [BAND_BITS-1:0]  band_q, band_d;
  logic [CIRC_BITS-1:0]         crad_q, crad_d, cx_q, cx_d, cy_q, cy_d;
  logic signed [DB-1:0]         dec_q, dec_d;
  logic [CB-1:0]                hx_q, hx_d, hy_q, hy_d;

  // combinational helpers
  logic [1:0]                   n_last;
  logic [CB-1:0]                px, py;
  logic [CB-1:0]                rad16, band16, cx16, cy16;
  logic signed [EB-1:0]         i_rad, i_l, i_t, i_r, i_b;
  logic signed [BAND_BITS-1:0]  half_s, neg_half, band_nx, neg_half_new;
  logic signed [EB-1:0]         edge_nx;
  logic signed [CRAD_BITS-1:0]  cr_val;
  logic signed [CIRC_BITS:0]    sq_op;
  logic signed [MB-1:0]         sq_prod;
  logic signed [DB-1:0]         dec_a, cx_s, cy_s, cxn_s, cyn_s, prod2;
  logic [CIRC_BITS-1:0]         cy_m1, cx_p1;

  assign half_s   = $signed(BAND_BITS'(half_q));
  assign neg_half = -half_s;
  assign neg_half_new = -$signed(BAND_BITS'(line_width_i >> 1));
  assign rad16    = CB'(rad_q);
  assign band16   = CB'(band_q);
  assign cx16     = CB'(cx_q);
  assign cy16     = CB'(cy_q);

  assign i_rad = $signed(EB'(item_i.corner_radius));
  assign i_l   = EB'(item_i.left_x);
  assign i_t   = EB'(item_i.top_y);
  assign i_r   = EB'(item_i.right_x);
  assign i_b   = EB'(item_i.bottom_y);

  // pixel of the current step selected by k_q
  always_comb begin
    n_last = 2'd3;
    px     = '0;
    py     = '0;
    unique case (phase_q)
      PH_HEDGE: begin
        n_last = 2'd1;
        px     = edge_q[CB-1:0];
        py     = ((k_q == 2'd0) ? t_q : b_q) - band16;
      end
      PH_VEDGE: begin
        n_last = 2'd1;
        px     = ((k_q == 2'd0) ? l_q : r_q) + band16;
        py     = edge_q[CB-1:0];
      end
      PH_REG1, PH_REG2: begin
        px = k_q[1] ? (l_q + rad16 - cx16) : (r_q - rad16 + cx16);
        py = k_q[0] ? (t_q - rad16 + cy16) : (b_q + rad16 - cy16);
      end
      default: begin
        n_last = 2'd3;
      end
    endcase
  end

  // one square per cycle while opening region two
  always_comb begin
    unique case (sq_q)
      SQ_X:    sq_op = $signed({1'b0, cx_q});
      SQ_Y:    sq_op = $signed({1'b0, cy_q}) - (CIRC_BITS+1)'(1);
      default: sq_op = $signed({1'b0, crad_q});
    endcase
    sq_prod = sq_op * sq_op;
    prod2   = DB'(sq_prod) <<< 1;
  end

  assign cr_val = $signed(CRAD_BITS'(rad_q)) - $signed(CRAD_BITS'(half_q))
                + $signed(CRAD_BITS'(pass_q));
  assign cy_m1  = cy_q - CIRC_BITS'(1);
  assign cx_p1  = cx_q + CIRC_BITS'(1);
  assign cx_s   = $signed(DB'(cx_q));
  assign cy_s   = $signed(DB'(cy_q));
  assign cxn_s  = $signed(DB'(cx_p1));
  assign cyn_s  = $signed(DB'(cy_m1));

  // next state
  always_comb begin
    seq_d   = seq_q;   phase_d = phase_q; sq_d  = sq_q;   k_d    = k_q;
    tick_d  = tick_q;  lw_d    = lw_q;    pass_d = pass_q; half_d = half_q;
    l_d = l_q; t_d = t_q; r_d = r_q; b_d = b_q; rad_d = rad_q; color_d = color_q;
    lpr_d = lpr_q; rmr_d = rmr_q; tmr_d = tmr_q; bpr_d = bpr_q;
    edge_d = edge_q; band_d = band_q; crad_d = crad_q;
    cx_d = cx_q; cy_d = cy_q; dec_d = dec_q; hx_d = hx_q; hy_d = hy_q;
    band_nx = band_q + BAND_BITS'(1);
    edge_nx = edge_q;
    dec_a   = dec_q;

    unique case (seq_q)
      ST_WAIT: begin
        if (item_valid_i) begin
          if (item_i.kind == KIND_DRAW) begin
            l_d     = item_i.left_x;
            t_d     = item_i.top_y;
            r_d     = item_i.right_x;
            b_d     = item_i.bottom_y;
            rad_d   = item_i.corner_radius;
            color_d = item_i.color;
            lpr_d   = i_l + i_rad;
            rmr_d   = i_r - i_rad;
            tmr_d   = i_t - i_rad;
            bpr_d   = i_b + i_rad;
            lw_d    = line_width_i;
            half_d  = HALF_BITS'(line_width_i >> 1);
            band_d  = neg_half_new;
            edge_d  = i_l + i_rad;
            pass_d  = '0;
            phase_d = PH_HEDGE;
            tick_d  = 1'b0;
            seq_d   = ST_SETTLE;
          end else if (phase_q != PH_IDLE) begin
            tick_d = 1'b1;
            k_d    = '0;
            seq_d  = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (k_q != n_last) begin
          if (!pix_full_i) begin
            k_d = k_q + 2'd1;
          end
        end else begin
          hx_d  = px;
          hy_d  = py;
          seq_d = ST_SETTLE;
          unique case (phase_q)
            PH_HEDGE: begin
              edge_nx = edge_q + EB'(1);
              edge_d  = edge_nx;
              if (edge_nx > rmr_q) begin
                edge_d = lpr_q;
                band_d = band_nx;
                if (band_nx > half_s) begin
                  phase_d = PH_VEDGE;
                  band_d  = neg_half;
                  edge_d  = tmr_q;
                end
              end
            end
            PH_VEDGE: begin
              edge_nx = edge_q - EB'(1);
              edge_d  = edge_nx;
              if (edge_nx < bpr_q) begin
                edge_d = tmr_q;
                band_d = band_nx;
                if (band_nx > half_s) begin
                  phase_d = PH_CSTART;
                  pass_d  = '0;
                end
              end
            end
            PH_REG1: begin
              if (dec_q >= 0) begin
                cy_d  = cy_m1;
                dec_a = dec_q - (cyn_s <<< 2);
              end
              dec_d = dec_a + DB'(6) + (cx_s <<< 2);
              cx_d  = cx_p1;
            end
            PH_REG2: begin
              if (dec_q <= 0) begin
                cx_d  = cx_p1;
                dec_a = dec_q + (cxn_s <<< 2);
              end
              cy_d  = cy_m1;
              dec_d = dec_a + DB'(6) - (cyn_s <<< 2);
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end

      ST_SETTLE: begin
        unique case (phase_q)
          PH_HEDGE: begin
            if (lpr_q > rmr_q) begin
              phase_d = PH_VEDGE;
              band_d  = neg_half;
              edge_d  = tmr_q;
            end else begin
              seq_d = tick_q ? ST_LAST : ST_WAIT;
            end
          end
          PH_VEDGE: begin
            if (tmr_q < bpr_q) begin
              phase_d = PH_CSTART;
              pass_d  = '0;
            end else begin
              seq_d = tick_q ? ST_LAST : ST_WAIT;
            end
          end
          PH_CSTART: begin
            if (pass_q >= lw_q) begin
              phase_d = PH_IDLE;
              seq_d   = tick_q ? ST_LAST : ST_WAIT;
            end else if (cr_val < $signed(CRAD_BITS'(1))) begin
              pass_d = pass_q + LW_BITS'(1);
            end else begin
              crad_d  = cr_val[CIRC_BITS-1:0];
              cx_d    = '0;
              cy_d    = cr_val[CIRC_BITS-1:0];
              dec_d   = DB'(3) - (DB'(cr_val) <<< 1);
              phase_d = PH_REG1;
            end
          end
          PH_REG1: begin
            if (cy_q > cx_q) begin
              seq_d = tick_q ? ST_LAST : ST_WAIT;
            end else begin
              sq_d  = SQ_X;
              seq_d = ST_SQUARE;
            end
          end
          PH_REG2: begin
            if (cy_q != '0) begin
              seq_d = tick_q ? ST_LAST : ST_WAIT;
            end else begin
              pass_d  = pass_q + LW_BITS'(1);
              phase_d = PH_CSTART;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            seq_d   = tick_q ? ST_LAST : ST_WAIT;
          end
        endcase
      end

      // 2x^2 + 2x + 1, then + 2(y-1)^2, then - 2r^2
      ST_SQUARE: begin
        unique case (sq_q)
          SQ_X: begin
            dec_d = prod2 + (cx_s <<< 1) + DB'(1);
            sq_d  = SQ_Y;
          end
          SQ_Y: begin
            dec_d = dec_q + prod2;
            sq_d  = SQ_R;
          end
          default: begin
            dec_d   = dec_q - prod2;
            phase_d = PH_REG2;
            seq_d   = ST_SETTLE;
          end
        endcase
      end

      ST_LAST: begin
        if (!pix_full_i) begin
          seq_d = ST_WAIT;
        end
      end

      default: begin
        seq_d = ST_WAIT;
      end
    endcase
  end

  // outputs
  always_comb begin
    item_take_o = 1'b0;
    pix_valid_o = 1'b0;
    pix_o       = '{x: px, y: py, color: color_q, step_last: 1'b0, shape_done: 1'b0};
    unique case (seq_q)
      ST_WAIT: item_take_o = 1'b1;
      ST_EMIT: pix_valid_o = (k_q != n_last);
      ST_LAST: begin
        pix_valid_o = 1'b1;
        pix_o = '{x: hx_q, y: hy_q, color: color_q, step_last: 1'b1,
                  shape_done: (phase_q == PH_IDLE)};
      end
      default: pix_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= ST_WAIT;
      phase_q <= PH_IDLE;
      sq_q    <= SQ_X;
      k_q     <= '0;
      tick_q  <= 1'b0;
      lw_q    <= '0;
      pass_q  <= '0;
      half_q  <= '0;
      band_q  <= '0;
      edge_q  <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      crad_q  <= '0;
      dec_q   <= '0;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
      sq_q    <= sq_d;
      k_q     <= k_d;
      tick_q  <= tick_d;
      lw_q    <= lw_d;
      pass_q  <= pass_d;
      half_q  <= half_d;
      band_q  <= band_d;
      edge_q  <= edge_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      crad_q  <= crad_d;
      dec_q   <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q     <= l_d;
    t_q     <= t_d;
    r_q     <= r_d;
    b_q     <= b_d;
    rad_q   <= rad_d;
    color_q <= color_d;
    lpr_q   <= lpr_d;
    rmr_q   <= rmr_d;
    tmr_q   <= tmr_d;
    bpr_q   <= bpr_d;
    hx_q    <= hx_d;
    hy_q    <= hy_d;
  end

endmodule

// ===== hdl/rounded_rect_outline_rasterizer.sv =====
// ----------------------------------------------------------------------------
// rounded_rect_outline_rasterizer
// Outline of a rounded rectangle: straight edges, then midpoint-circle corners.
// ----------------------------------------------------------------------------
//   channel  handshake               payload
//   input    push / full             kind, left_x, top_y, right_x, bottom_y,
//                                    corner_radius, color
//   result   empty / pop             pixel_x, pixel_y, pixel_color,
//                                    step_last, shape_done
//   config   cfg_valid / cfg_ready   line_width (always ready)
//
// The sequencer works on one item at a time. A tick is taken from the queue,
// emits every pixel of the current step but the last, updates the step, settles
// and then sends the last pixel; pass changes add a settle step each, and the
// squares of x, y and r are formed on entering region two.
// A full result queue stalls the sequencer; a two-item input queue lets
// items arrive meanwhile. Reset clears all control state, line_width to 1.
module rounded_rect_outline_rasterizer import rrr_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          kind_i,
  input  logic signed [COORD_BITS-1:0]  left_x_i,
  input  logic signed [COORD_BITS-1:0]  top_y_i,
  input  logic signed [COORD_BITS-1:0]  right_x_i,
  input  logic signed [COORD_BITS-1:0]  bottom_y_i,
  input  logic [RADIUS_BITS-1:0]        corner_radius_i,
  input  logic [COLOR_BITS-1:0]         color_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [COORD_BITS-1:0]  pixel_x_o,
  output logic signed [COORD_BITS-1:0]  pixel_y_o,
  output logic [COLOR_BITS-1:0]         pixel_color_o,
  output logic                          step_last_o,
  output logic                          shape_done_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [LW_BITS-1:0]            cfg_data_i
);

  logic [LW_BITS-1:0] line_width_q;
  item_t  in_item, q_item;
  logic   q_valid, q_take;
  logic   pix_valid, pix_full;
  pixel_t pix, out_pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LW_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      line_width_q <= cfg_data_i;
    end
  end

  always_comb begin
    in_item = '{kind: KIND_DRAW, left_x: left_x_i, top_y: top_y_i, right_x: right_x_i,
                bottom_y: bottom_y_i, corner_radius: corner_radius_i, color: color_i};
  end

  rrr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .kind_bit_i   (kind_i),
    .item_i       (in_item),
    .full_o       (full),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_take_i  (q_take)
  );

  rrr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (line_width_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_take_o  (q_take),
    .pix_valid_o  (pix_valid),
    .pix_o        (pix),
    .pix_full_i   (pix_full)
  );

  rrr_out_q u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .pix_full_o  (pix_full),
    .empty_o     (empty),
    .pop_i       (pop),
    .pix_o       (out_pix)
  );

  assign pixel_x_o     = out_pix.x;
  assign pixel_y_o     = out_pix.y;
  assign pixel_color_o = out_pix.color;
  assign step_last_o   = out_pix.step_last;
  assign shape_done_o  = out_pix.shape_done;

endmodule

// ===== verif/tb_rounded_rect_outline_rasterizer.sv =====
// ----------------------------------------------------------------------------
// tb_rounded_rect_outline_rasterizer
// Self-checking bench: draw commands and ticks go in through the input queue.
// A behavioural rasterizer predicts every pixel, and each popped pixel is
// checked against it. The line width is changed between traffic phases.
// ----------------------------------------------------------------------------
module tb_rounded_rect_outline_rasterizer import rrr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic kind_i = 1'b0;
  logic signed [COORD_BITS-1:0] left_x_i = '0;
  logic signed [COORD_BITS-1:0] top_y_i = '0;
  logic signed [COORD_BITS-1:0] right_x_i = '0;
  logic signed [COORD_BITS-1:0] bottom_y_i = '0;
  logic [RADIUS_BITS-1:0] corner_radius_i = '0;
  logic [COLOR_BITS-1:0] color_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [COORD_BITS-1:0] pixel_x_o;
  logic signed [COORD_BITS-1:0] pixel_y_o;
  logic [COLOR_BITS-1:0] pixel_color_o;
  logic step_last_o;
  logic shape_done_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LW_BITS-1:0] cfg_data_i = '0;

  rounded_rect_outline_rasterizer dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  item_t pending_items[$];
  pixel_t expected_pixels[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;

  // raster state
  int        lw_setting = 1;
  int        lw_shape = 0;
  int        corner[4];
  int        shape_rad = 0;
  logic [COLOR_BITS-1:0] shape_col = '0;
  phase_e    ph = PH_IDLE;
  int        band = 0;
  int        epos = 0;
  int        pass_no = 0;
  longint    crad = 0, cx = 0, cy = 0, dec = 0;
  pixel_t    step_px[4];

  function automatic void put_pixel(int k, longint x, longint y);
    step_px[k].x = x[COORD_BITS-1:0];
    step_px[k].y = y[COORD_BITS-1:0];
    step_px[k].color = shape_col;
    step_px[k].step_last = 1'b0;
    step_px[k].shape_done = 1'b0;
  endfunction

  function automatic void put_corners();
    longint xn, yn, xl, yt;
    xn = longint'(corner[2]) - shape_rad;
    yn = longint'(corner[3]) + shape_rad;
    xl = longint'(corner[0]) + shape_rad;
    yt = longint'(corner[1]) - shape_rad;
    put_pixel(0, cx + xn, yn - cy);
    put_pixel(1, cx + xn, yt + cy);
    put_pixel(2, xl - cx, yn - cy);
    put_pixel(3, xl - cx, yt + cy);
  endfunction

  // skip empty loops and open the next corner pass until a step is pending
  function automatic void advance_to_step();
    int half;
    longint sq;
    half = lw_shape / 2;
    while (1) begin
      case (ph)
        PH_HEDGE: begin
          if (corner[0] + shape_rad > corner[2] - shape_rad) begin
            ph = PH_VEDGE;
            band = -half;
            epos = corner[1] - shape_rad;
            continue;
          end
          return;
        end
        PH_VEDGE: begin
          if (corner[1] - shape_rad < corner[3] + shape_rad) begin
            ph = PH_CSTART;
            pass_no = 0;
            continue;
          end
          return;
        end
        PH_CSTART: begin
          if (pass_no >= lw_shape) begin
            ph = PH_IDLE;
            return;
          end
          crad = longint'(shape_rad) - half + pass_no;
          if (crad < 1) begin
            pass_no++;
            continue;
          end
          sq = crad * crad;
          cx = 0;
          cy = crad;
          dec = 2 * sq * ((cy - 1) * cy) + sq + 2 * sq * (1 - sq);
          ph = PH_REG1;
          continue;
        end
        PH_REG1: begin
          if (cy > cx) return;
          sq = crad * crad;
          dec = 2 * sq * (cx + 1) * cx + 2 * sq * (cy * (cy - 2) + 1) + (1 - 2 * sq) * sq;
          ph = PH_REG2;
          continue;
        end
        PH_REG2: begin
          if (cy != 0) return;
          pass_no++;
          ph = PH_CSTART;
          continue;
        end
        default: begin
          ph = PH_IDLE;
          return;
        end
      endcase
    end
  endfunction

  function automatic void rasterize_item(item_t it);
    int n, half;
    longint sq;
    n = 0;
    if (it.kind == KIND_DRAW) begin
      corner[0] = int'(it.left_x);
      corner[1] = int'(it.top_y);
      corner[2] = int'(it.right_x);
      corner[3] = int'(it.bottom_y);
      shape_rad = int'({1'b0, it.corner_radius});
      shape_col = it.color;
      lw_shape = lw_setting;
      band = -(lw_shape / 2);
      epos = corner[0] + shape_rad;
      pass_no = 0;
      ph = PH_HEDGE;
      advance_to_step();
      return;
    end
    half = lw_shape / 2;
    case (ph)
      PH_HEDGE: begin
        put_pixel(0, epos, longint'(corner[1]) - band);
        put_pixel(1, epos, longint'(corner[3]) - band);
        n = 2;
        epos++;
        if (epos > corner[2] - shape_rad) begin
          epos = corner[0] + shape_rad;
          band++;
          if (band > half) begin
            ph = PH_VEDGE;
            band = -half;
            epos = corner[1] - shape_rad;
          end
        end
      end
      PH_VEDGE: begin
        put_pixel(0, longint'(corner[0]) + band, epos);
        put_pixel(1, longint'(corner[2]) + band, epos);
        n = 2;
        epos--;
        if (epos < corner[3] + shape_rad) begin
          epos = corner[1] - shape_rad;
          band++;
          if (band > half) begin
            ph = PH_CSTART;
            pass_no = 0;
          end
        end
      end
      PH_REG1: begin
        put_corners();
        n = 4;
        sq = crad * crad;
        if (dec >= 0) begin
          cy--;
          dec -= 4 * sq * cy;
        end
        dec += 2 * sq * (3 + 2 * cx);
        cx++;
      end
      PH_REG2: begin
        put_corners();
        n = 4;
        sq = crad * crad;
        if (dec <= 0) begin
          cx++;
          dec += 4 * sq * cx;
        end
        cy--;
        dec += 2 * sq * (3 - 2 * cy);
      end
      default: begin
        ph = PH_IDLE;
        return;
      end
    endcase
    advance_to_step();
    step_px[n-1].step_last = 1'b1;
    if (ph == PH_IDLE) step_px[n-1].shape_done = 1'b1;
    for (int k = 0; k < n; k++) expected_pixels.push_back(step_px[k]);
  endfunction

  // sender
  item_t cur_item;
  always @(posedge clk_i) begin
    logic busy;
    busy = push;
    if (push && !full) begin
      rasterize_item(cur_item);
      busy = 1'b0;
    end
    if (!busy) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_item = pending_items.pop_front();
        kind_i <= cur_item.kind;
        left_x_i <= cur_item.left_x;
        top_y_i <= cur_item.top_y;
        right_x_i <= cur_item.right_x;
        bottom_y_i <= cur_item.bottom_y;
        corner_radius_i <= cur_item.corner_radius;
        color_i <= cur_item.color;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  function automatic void check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // receiver
  always @(posedge clk_i) begin
    pixel_t want;
    if (pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, actual x=%0h y=%0h", $realtime, pixel_x_o, pixel_y_o);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", want.x, pixel_x_o[COORD_BITS-1:0]);
        check_field("pixel_y", want.y, pixel_y_o[COORD_BITS-1:0]);
        check_field("pixel_color", want.color, pixel_color_o);
        check_field("step_last", want.step_last, step_last_o);
        check_field("shape_done", want.shape_done, shape_done_o);
      end
    end
    if (rst_ni && hold_cycles == 0) pop <= ($urandom_range(99) >= recv_stall_pct);
    else pop <= 1'b0;
  end

  function automatic item_t tick_item();
    item_t it;
    logic [3*32-1:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = item_t'(raw[$bits(item_t)-1:0]);
    it.kind = KIND_TICK;
    return it;
  endfunction

  function automatic item_t draw_item(int l, int t, int r, int b, int rad, int col);
    item_t it;
    it.kind = KIND_DRAW;
    it.left_x = l[COORD_BITS-1:0];
    it.top_y = t[COORD_BITS-1:0];
    it.right_x = r[COORD_BITS-1:0];
    it.bottom_y = b[COORD_BITS-1:0];
    it.corner_radius = rad[RADIUS_BITS-1:0];
    it.color = col[COLOR_BITS-1:0];
    return it;
  endfunction

  function automatic item_t random_draw();
    int l, b, w, h;
    if ($urandom_range(9) == 0) begin
      return draw_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    l = $urandom_range(1, 0) ? $urandom_range(65535) : $urandom_range(40);
    b = $urandom_range(1, 0) ? $urandom_range(65535) : $urandom_range(40);
    w = $urandom_range(14) - ($urandom_range(7) == 0 ? 10 : 0);
    h = $urandom_range(14) - ($urandom_range(7) == 0 ? 10 : 0);
    return draw_item(l, b + h, l + w, b, $urandom_range(6), $urandom);
  endfunction

  task automatic queue_random(int count);
    int sent;
    int ticks;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) != 0) begin
        pending_items.push_back(random_draw());
        sent++;
      end
      ticks = $urandom_range(60);
      repeat (ticks) pending_items.push_back(tick_item());
      sent += ticks;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || push || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_line_width(int value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value[LW_BITS-1:0];
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    lw_setting = value;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle ticks, extremes, swapped, empty, a finished small shape
    write_line_width(1);
    pending_items.push_back(tick_item());
    pending_items.push_back(tick_item());
    pending_items.push_back(draw_item(-32768, 32767, 32767, -32768, 0, 'hffff));
    repeat (4) pending_items.push_back(tick_item());
    pending_items.push_back(draw_item(10, 5, 2, 0, 1, 'h1234));
    repeat (3) pending_items.push_back(tick_item());
    pending_items.push_back(draw_item(5, 0, 2, 3, 0, 'h0));
    pending_items.push_back(tick_item());
    pending_items.push_back(draw_item(0, 2, 2, 0, 1, 'h5a5a));
    repeat (8) pending_items.push_back(tick_item());
    pending_items.push_back(draw_item(32760, -32760, -32760, 32760, 2047, 'ha5a5));
    repeat (3) pending_items.push_back(tick_item());
    wait_drained();

    write_line_width(0);
    queue_random(55);
    wait_drained();

    write_line_width(63);
    send_idle_pct = 56;
    queue_random(55);
    wait_drained();

    write_line_width(3);
    send_idle_pct = 0;
    recv_stall_pct = 56;
    hold_cycles = 400;
    queue_random(55);
    wait_drained();

    write_line_width($urandom_range(63));
    send_idle_pct = 22;
    recv_stall_pct = 22;
    queue_random(55);
    wait_drained();

    write_line_width(2);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random(45);
    wait_drained();

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
